// ----- hdl/mpub_pkg.sv -----
package mpub_pkg;

  // Longest remaining-length varint, in bytes.
  localparam int LENGTH_BYTES_MAX = 4;

  localparam int LEN_W   = 28;
  localparam int FIELD_W = 16;
  localparam int CNT_W   = 3;

  localparam logic [7:0] CONT_MASK  = 8'h80;
  localparam logic [7:0] QOS_MASK   = 8'h06;
  localparam int         GROUP_BITS = 7;

  typedef enum logic [2:0] {
    PH_HEADER  = 3'd0,
    PH_LENGTH  = 3'd1,
    PH_TLEN    = 3'd2,
    PH_TOPIC   = 3'd3,
    PH_ID      = 3'd4,
    PH_PAYLOAD = 3'd5,
    PH_SKIPCNT = 3'd6,
    PH_SKIPALL = 3'd7
  } phase_t;

  typedef enum logic [2:0] {
    KIND_HEADER    = 3'd0,
    KIND_LENGTH    = 3'd1,
    KIND_TOPIC_LEN = 3'd2,
    KIND_TOPIC     = 3'd3,
    KIND_ID        = 3'd4,
    KIND_PAYLOAD   = 3'd5,
    KIND_DISCARD   = 3'd6
  } kind_t;

  typedef enum logic [1:0] {
    ERR_NONE     = 2'd0,
    ERR_LEN_LONG = 2'd1,
    ERR_SHORT    = 2'd2
  } err_t;

  typedef struct packed {
    logic [7:0] byte_value;
    logic       start_req;
  } in_item_t;

  typedef struct packed {
    logic [2:0]         byte_kind;
    logic [7:0]         data_byte;
    logic [1:0]         qos;
    logic [FIELD_W-1:0] topic_length;
    logic [FIELD_W-1:0] packet_id;
    logic [LEN_W-1:0]   payload_length;
    logic               last;
    logic [1:0]         error_code;
  } out_item_t;

endpackage

// ----- hdl/mpub_if.sv -----
interface mpub_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_value;
  logic       start_req;

  modport source (output valid, output byte_value, output start_req, input ready);
  modport sink   (input valid, input byte_value, input start_req, output ready);
endinterface

interface mpub_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  byte_kind;
  logic [7:0]  data_byte;
  logic [1:0]  qos;
  logic [15:0] topic_length;
  logic [15:0] packet_id;
  logic [27:0] payload_length;
  logic        last;
  logic [1:0]  error_code;

  modport source (output valid, output byte_kind, output data_byte, output qos,
                  output topic_length, output packet_id, output payload_length,
                  output last, output error_code, input ready);
  modport sink   (input valid, input byte_kind, input data_byte, input qos,
                  input topic_length, input packet_id, input payload_length,
                  input last, input error_code, output ready);
endinterface

// ----- hdl/mpub_in_stage.sv -----
module mpub_in_stage (
  input  logic               clk,
  input  logic               rst,
  mpub_in_if.sink            in_ch,
  input  logic               take,
  output mpub_pkg::in_item_t item,
  output logic               item_valid
);
  import mpub_pkg::*;

  // Refill when empty or when the held item moves on this cycle.
  assign in_ch.ready = !item_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_ch.ready) begin
      item_valid <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      item.byte_value <= in_ch.byte_value;
      item.start_req  <= in_ch.start_req;
    end
  end

endmodule

// ----- hdl/mpub_decoder.sv -----
module mpub_decoder (
  input  logic                clk,
  input  logic                rst,
  input  mpub_pkg::in_item_t  item,
  input  logic                advance,
  output mpub_pkg::out_item_t res
);
  import mpub_pkg::*;

  phase_t             phase, phase_next;
  logic [1:0]         qos_held, qos_next;
  logic [LEN_W-1:0]   length_accum, length_accum_next;
  logic [CNT_W-1:0]   length_byte_count, length_byte_count_next;
  logic [LEN_W-1:0]   remaining_count, remaining_count_next;
  logic [FIELD_W-1:0] topic_len_held, topic_len_held_next;
  logic [FIELD_W-1:0] field_count, field_count_next;
  logic [FIELD_W-1:0] id_held, id_held_next;
  logic               sized, sized_next;

  logic [7:0]         b;
  logic [LEN_W-1:0]   rem_dec;
  logic [FIELD_W-1:0] fc_inc;
  logic [FIELD_W-1:0] tl_full;
  logic [LEN_W-1:0]   id_bytes_held;
  logic [LEN_W-1:0]   id_bytes_next;
  logic [CNT_W-1:0]   cnt_inc;
  logic [LEN_W-1:0]   group_shifted;
  logic [LEN_W-1:0]   acc_or;
  logic [LEN_W-1:0]   skip_rem;
  logic [LEN_W-1:0]   used;
  logic               go_after_topic;
  kind_t              kind;
  err_t               err;
  logic               last;
  logic [LEN_W-1:0]   plen;

  assign b             = item.byte_value;
  assign rem_dec       = remaining_count - LEN_W'(1);
  assign fc_inc        = field_count + FIELD_W'(1);
  assign tl_full       = {topic_len_held[15:8], b};
  assign id_bytes_held = (qos_held != 2'd0) ? LEN_W'(2) : '0;
  assign cnt_inc       = length_byte_count + CNT_W'(1);
  assign group_shifted = LEN_W'(b & ~CONT_MASK)
                         << (5'(length_byte_count[1:0]) * 5'(GROUP_BITS));
  assign acc_or        = length_byte_count[2] ? length_accum
                                              : (length_accum | group_shifted);
  assign skip_rem      = (remaining_count != '0) ? rem_dec : '0;

  always_comb begin
    phase_next             = phase;
    qos_next               = qos_held;
    length_accum_next      = length_accum;
    length_byte_count_next = length_byte_count;
    remaining_count_next   = remaining_count;
    topic_len_held_next    = topic_len_held;
    field_count_next       = field_count;
    id_held_next           = id_held;
    sized_next             = sized;
    kind                   = KIND_DISCARD;
    err                    = ERR_NONE;
    last                   = 1'b0;
    go_after_topic         = 1'b0;

    if (item.start_req || phase == PH_HEADER) begin
      kind                   = KIND_HEADER;
      qos_next               = 2'((b & QOS_MASK) >> 1);
      length_accum_next      = '0;
      length_byte_count_next = '0;
      remaining_count_next   = '0;
      topic_len_held_next    = '0;
      field_count_next       = '0;
      id_held_next           = '0;
      sized_next             = 1'b0;
      phase_next             = PH_LENGTH;
    end else begin
      unique case (phase)
        PH_LENGTH: begin
          kind                   = KIND_LENGTH;
          length_accum_next      = acc_or;
          length_byte_count_next = cnt_inc;
          if ((b & CONT_MASK) != 8'd0) begin
            if (cnt_inc >= CNT_W'(LENGTH_BYTES_MAX)) begin
              err        = ERR_LEN_LONG;
              last       = 1'b1;
              phase_next = PH_SKIPALL;
            end
          end else begin
            remaining_count_next = acc_or;
            if (acc_or < LEN_W'(2)) begin
              err = ERR_SHORT;
              if (acc_or == '0) begin
                last       = 1'b1;
                phase_next = PH_HEADER;
              end else begin
                phase_next = PH_SKIPCNT;
              end
            end else begin
              field_count_next = '0;
              phase_next       = PH_TLEN;
            end
          end
        end
        PH_TLEN: begin
          kind                 = KIND_TOPIC_LEN;
          remaining_count_next = rem_dec;
          if (field_count == '0) begin
            topic_len_held_next = {b, 8'h00};
            field_count_next    = FIELD_W'(1);
          end else begin
            topic_len_held_next = tl_full;
            if ((LEN_W'(tl_full) + id_bytes_held) > rem_dec) begin
              err = ERR_SHORT;
              if (rem_dec == '0) begin
                last       = 1'b1;
                phase_next = PH_HEADER;
              end else begin
                phase_next = PH_SKIPCNT;
              end
            end else begin
              sized_next = 1'b1;
              if (tl_full != '0) begin
                field_count_next = '0;
                phase_next       = PH_TOPIC;
              end else begin
                go_after_topic = 1'b1;
              end
            end
          end
        end
        PH_TOPIC: begin
          kind                 = KIND_TOPIC;
          remaining_count_next = rem_dec;
          field_count_next     = fc_inc;
          go_after_topic       = (fc_inc >= topic_len_held);
        end
        PH_ID: begin
          kind                 = KIND_ID;
          remaining_count_next = rem_dec;
          id_held_next         = {id_held[7:0], b};
          field_count_next     = fc_inc;
          if (fc_inc >= FIELD_W'(2)) begin
            field_count_next = '0;
            if (rem_dec == '0) begin
              last       = 1'b1;
              phase_next = PH_HEADER;
            end else begin
              phase_next = PH_PAYLOAD;
            end
          end
        end
        PH_PAYLOAD: begin
          kind                 = KIND_PAYLOAD;
          remaining_count_next = rem_dec;
          if (rem_dec == '0) begin
            last       = 1'b1;
            phase_next = PH_HEADER;
          end
        end
        PH_SKIPCNT: begin
          kind                 = KIND_DISCARD;
          remaining_count_next = skip_rem;
          if (skip_rem == '0) begin
            last       = 1'b1;
            phase_next = PH_HEADER;
          end
        end
        default: begin
          kind = KIND_DISCARD;
        end
      endcase

      // Leave the topic: identifier next, payload next, or end of packet.
      if (go_after_topic) begin
        field_count_next = '0;
        if (qos_held != 2'd0) begin
          phase_next = PH_ID;
        end else if (rem_dec == '0) begin
          last       = 1'b1;
          phase_next = PH_HEADER;
        end else begin
          phase_next = PH_PAYLOAD;
        end
      end
    end
  end

  assign id_bytes_next = (qos_next != 2'd0) ? LEN_W'(2) : '0;
  assign used = LEN_W'(2) + LEN_W'(topic_len_held_next) + id_bytes_next;

  always_comb begin
    plen = '0;
    if (sized_next && length_accum_next >= used) begin
      plen = length_accum_next - used;
    end
  end

  always_comb begin
    res.byte_kind      = kind;
    res.data_byte      = b;
    res.qos            = qos_next;
    res.topic_length   = topic_len_held_next;
    res.packet_id      = id_held_next;
    res.payload_length = plen;
    res.last           = last;
    res.error_code     = err;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= PH_HEADER;
      qos_held          <= '0;
      length_accum      <= '0;
      length_byte_count <= '0;
      remaining_count   <= '0;
      topic_len_held    <= '0;
      field_count       <= '0;
      id_held           <= '0;
      sized             <= 1'b0;
    end else if (advance) begin
      phase             <= phase_next;
      qos_held          <= qos_next;
      length_accum      <= length_accum_next;
      length_byte_count <= length_byte_count_next;
      remaining_count   <= remaining_count_next;
      topic_len_held    <= topic_len_held_next;
      field_count       <= field_count_next;
      id_held           <= id_held_next;
      sized             <= sized_next;
    end
  end

  a_overlong_skips: assert property (@(posedge clk) disable iff (rst)
    advance && res.error_code == ERR_LEN_LONG |=> phase == PH_SKIPALL)
    else $error("overlong length did not enter discard-all");

  a_last_closes: assert property (@(posedge clk) disable iff (rst)
    advance && res.last |=> phase == PH_HEADER || phase == PH_SKIPALL)
    else $error("last byte did not close the packet");

  a_len_count_bound: assert property (@(posedge clk) disable iff (rst)
    length_byte_count <= CNT_W'(LENGTH_BYTES_MAX))
    else $error("length byte count past limit");

  a_no_id_at_qos0: assert property (@(posedge clk) disable iff (rst)
    qos_held == 2'd0 |-> id_held == '0)
    else $error("identifier held while QoS is zero");

endmodule

// ----- hdl/mpub_out_stage.sv -----
module mpub_out_stage (
  input  logic                clk,
  input  logic                rst,
  input  mpub_pkg::out_item_t res,
  input  logic                res_valid,
  output logic                take,
  mpub_out_if.source          out_ch
);
  import mpub_pkg::*;

  out_item_t res_q;

  // Load a new result when the register is empty or being drained.
  assign take = !out_ch.valid || out_ch.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_ch.valid <= 1'b0;
    end else if (take) begin
      out_ch.valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take && res_valid) begin
      res_q <= res;
    end
  end

  assign out_ch.byte_kind      = res_q.byte_kind;
  assign out_ch.data_byte      = res_q.data_byte;
  assign out_ch.qos            = res_q.qos;
  assign out_ch.topic_length   = res_q.topic_length;
  assign out_ch.packet_id      = res_q.packet_id;
  assign out_ch.payload_length = res_q.payload_length;
  assign out_ch.last           = res_q.last;
  assign out_ch.error_code     = res_q.error_code;

endmodule

// ----- hdl/mqtt_publish_byte_parser.sv -----
// Channel   Role   Item fields
// in_ch     sink   byte_value[7:0], start_req
// out_ch    source byte_kind[2:0], data_byte[7:0], qos[1:0], topic_length[15:0],
//                  packet_id[15:0], payload_length[27:0], last, error_code[1:0]
//
// One result item per input item, one item per cycle sustained while out_ch does not stall.
// Each item passes through the input register, then the decode into the result register.
// The parser state advances when the input register hands its item to the result register.
// rst (synchronous) returns the parser to waiting for a fixed header.
// A stall on out_ch holds the result register; in_ch keeps taking items until
// the input register is full as well.
module mqtt_publish_byte_parser (
  input logic         clk,
  input logic         rst,
  mpub_in_if.sink     in_ch,
  mpub_out_if.source  out_ch
);
  import mpub_pkg::*;

  in_item_t  item;
  logic      item_valid;
  logic      take;
  logic      advance;
  out_item_t res;

  // Move the held byte through the decoder whenever the result register can load.
  assign advance = item_valid && take;

  mpub_in_stage u_in_stage (
    .clk        (clk),
    .rst        (rst),
    .in_ch      (in_ch),
    .take       (take),
    .item       (item),
    .item_valid (item_valid)
  );

  // Phase tracking, varint decode, field capture and length checks.
  mpub_decoder u_decoder (
    .clk     (clk),
    .rst     (rst),
    .item    (item),
    .advance (advance),
    .res     (res)
  );

  mpub_out_stage u_out_stage (
    .clk       (clk),
    .rst       (rst),
    .res       (res),
    .res_valid (item_valid),
    .take      (take),
    .out_ch    (out_ch)
  );

endmodule

// ----- tb/sv/mqtt_publish_byte_parser_checker.sv -----
module mqtt_publish_byte_parser_checker (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic                in_ready,
  input  logic [7:0]          in_byte,
  input  logic                in_start,
  input  logic                out_valid,
  input  logic                out_ready,
  input  mpub_pkg::out_item_t out_item,
  output int                  errors,
  output int                  pending
);
  import mpub_pkg::*;

  // Shadow copy of the parser state.
  phase_t             phase_q;
  logic [1:0]         qos_q;
  logic [LEN_W-1:0]   len_acc_q;
  logic [CNT_W-1:0]   len_cnt_q;
  logic [LEN_W-1:0]   remain_q;
  logic [FIELD_W-1:0] tlen_q;
  logic [FIELD_W-1:0] fcnt_q;
  logic [FIELD_W-1:0] pid_q;
  logic               sized_q;

  out_item_t byte_reports_due[$];

  task automatic report_mismatch(input string what);
    $display("[%0t] parser check: %s", $time, what);
    errors++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
  endtask

  function automatic int unsigned id_len();
    return (qos_q != 2'd0) ? 2 : 0;
  endfunction

  // End the packet here, or discard what the remaining length still counts.
  function automatic logic close_or_skip();
    if (remain_q == '0) begin
      phase_q = PH_HEADER;
      return 1'b1;
    end
    phase_q = PH_SKIPCNT;
    return 1'b0;
  endfunction

  function automatic logic leave_topic();
    fcnt_q = '0;
    if (qos_q != 2'd0) begin
      phase_q = PH_ID;
      return 1'b0;
    end
    if (remain_q == '0) begin
      phase_q = PH_HEADER;
      return 1'b1;
    end
    phase_q = PH_PAYLOAD;
    return 1'b0;
  endfunction

  task automatic parse_byte(input logic [7:0] b, input logic st, output out_item_t r);
    kind_t       kind;
    err_t        err;
    logic        lst;
    int unsigned used;
    kind = KIND_DISCARD;
    err  = ERR_NONE;
    lst  = 1'b0;
    if (st || phase_q == PH_HEADER) begin
      kind      = KIND_HEADER;
      qos_q     = 2'((b & QOS_MASK) >> 1);
      len_acc_q = '0;
      len_cnt_q = '0;
      remain_q  = '0;
      tlen_q    = '0;
      fcnt_q    = '0;
      pid_q     = '0;
      sized_q   = 1'b0;
      phase_q   = PH_LENGTH;
    end else begin
      case (phase_q)
        PH_LENGTH: begin
          kind = KIND_LENGTH;
          if (len_cnt_q < LENGTH_BYTES_MAX)
            len_acc_q = len_acc_q | (LEN_W'(b & ~CONT_MASK) << (GROUP_BITS * len_cnt_q));
          len_cnt_q = len_cnt_q + 1'b1;
          if ((b & CONT_MASK) != 8'h00) begin
            if (len_cnt_q >= LENGTH_BYTES_MAX) begin
              err     = ERR_LEN_LONG;
              lst     = 1'b1;
              phase_q = PH_SKIPALL;
            end
          end else begin
            remain_q = len_acc_q;
            if (remain_q < 2) begin
              err = ERR_SHORT;
              lst = close_or_skip();
            end else begin
              fcnt_q  = '0;
              phase_q = PH_TLEN;
            end
          end
        end
        PH_TLEN: begin
          kind     = KIND_TOPIC_LEN;
          remain_q = remain_q - 1'b1;
          if (fcnt_q == '0) begin
            tlen_q = {b, 8'h00};
            fcnt_q = 16'd1;
          end else begin
            tlen_q = tlen_q | FIELD_W'(b);
            if (tlen_q + id_len() > remain_q) begin
              err = ERR_SHORT;
              lst = close_or_skip();
            end else begin
              sized_q = 1'b1;
              if (tlen_q != '0) begin
                fcnt_q  = '0;
                phase_q = PH_TOPIC;
              end else begin
                lst = leave_topic();
              end
            end
          end
        end
        PH_TOPIC: begin
          kind     = KIND_TOPIC;
          remain_q = remain_q - 1'b1;
          fcnt_q   = fcnt_q + 1'b1;
          if (fcnt_q >= tlen_q)
            lst = leave_topic();
        end
        PH_ID: begin
          kind     = KIND_ID;
          remain_q = remain_q - 1'b1;
          pid_q    = {pid_q[7:0], b};
          fcnt_q   = fcnt_q + 1'b1;
          if (fcnt_q >= 2) begin
            fcnt_q = '0;
            if (remain_q == '0) begin
              phase_q = PH_HEADER;
              lst     = 1'b1;
            end else begin
              phase_q = PH_PAYLOAD;
            end
          end
        end
        PH_PAYLOAD: begin
          kind     = KIND_PAYLOAD;
          remain_q = remain_q - 1'b1;
          if (remain_q == '0) begin
            phase_q = PH_HEADER;
            lst     = 1'b1;
          end
        end
        PH_SKIPCNT: begin
          if (remain_q != '0)
            remain_q = remain_q - 1'b1;
          if (remain_q == '0) begin
            phase_q = PH_HEADER;
            lst     = 1'b1;
          end
        end
        default: ;
      endcase
    end

    r.payload_length = '0;
    if (sized_q) begin
      used = 2 + tlen_q + id_len();
      if (len_acc_q >= used)
        r.payload_length = LEN_W'(len_acc_q - used);
    end
    r.byte_kind    = kind;
    r.data_byte    = b;
    r.qos          = qos_q;
    r.topic_length = tlen_q;
    r.packet_id    = pid_q;
    r.last         = lst;
    r.error_code   = err;
  endtask

  always @(posedge clk) begin : watch
    out_item_t want;
    if (rst) begin
      phase_q   = PH_HEADER;
      qos_q     = '0;
      len_acc_q = '0;
      len_cnt_q = '0;
      remain_q  = '0;
      tlen_q    = '0;
      fcnt_q    = '0;
      pid_q     = '0;
      sized_q   = 1'b0;
      errors    = 0;
      byte_reports_due.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (byte_reports_due.size() == 0) begin
          report_mismatch("result item with nothing expected");
        end else begin
          want = byte_reports_due.pop_front();
          check_field("byte_kind", 32'(out_item.byte_kind), 32'(want.byte_kind));
          check_field("data_byte", 32'(out_item.data_byte), 32'(want.data_byte));
          check_field("qos", 32'(out_item.qos), 32'(want.qos));
          check_field("topic_length", 32'(out_item.topic_length), 32'(want.topic_length));
          check_field("packet_id", 32'(out_item.packet_id), 32'(want.packet_id));
          check_field("payload_length", 32'(out_item.payload_length),
                      32'(want.payload_length));
          check_field("last", 32'(out_item.last), 32'(want.last));
          check_field("error_code", 32'(out_item.error_code), 32'(want.error_code));
        end
      end
      if (in_valid && in_ready) begin
        parse_byte(in_byte, in_start, want);
        byte_reports_due.push_back(want);
      end
    end
    pending = byte_reports_due.size();
  end

endmodule

// ----- tb/sv/mqtt_publish_byte_parser_test.sv -----
module mqtt_publish_byte_parser_test;
  import mpub_pkg::*;

  // Random bytes to queue after the directed opening.
  localparam int          RANDOM_ITEMS = 400;
  // Cycle ceiling for the whole run; far above the slowest legal run.
  localparam int          CYCLE_LIMIT  = 200000;
  // Receiver hold-off that backs the parser up into its input register.
  localparam int          HOLD_CYCLES  = 80;
  localparam int          HOLD_AT      = 150;
  localparam int unsigned NO_CUT       = 32'hFFFF_FFFF;

  logic clk = 1'b0;
  logic rst;
  int   errors;
  int   pending;
  int   cycle_count = 0;
  int   sent_n = 0;
  bit   quiet = 1'b0;
  bit   holding = 1'b0;
  bit   hold_done = 1'b0;

  in_item_t byte_plan[$];

  mpub_in_if  in_ch ();
  mpub_out_if out_ch ();

  mqtt_publish_byte_parser dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  mqtt_publish_byte_parser_checker parse_check (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .in_byte   (in_ch.byte_value),
    .in_start  (in_ch.start_req),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_item  ({out_ch.byte_kind, out_ch.data_byte, out_ch.qos, out_ch.topic_length,
                 out_ch.packet_id, out_ch.payload_length, out_ch.last,
                 out_ch.error_code}),
    .errors    (errors),
    .pending   (pending)
  );

  always #2 clk = ~clk;

  // Queue one input byte.
  task automatic add_byte(input logic [7:0] b, input logic st);
    in_item_t it;
    it.byte_value = b;
    it.start_req  = st;
    byte_plan.push_back(it);
  endtask

  // Queue one packet: header, remaining length padded out to at least pad
  // groups, optional topic length, then body_n random bytes. Only the first
  // cut bytes go out, which leaves an aborted packet behind when cut is short.
  task automatic add_frame(input logic [7:0] head, input logic st, input int unsigned rem,
                           input int unsigned pad, input bit with_tlen,
                           input logic [15:0] tlen, input int unsigned body_n,
                           input int unsigned cut);
    logic [7:0]  lead[$];
    logic [7:0]  lb;
    int unsigned groups;
    int unsigned v;
    lead.push_back(head);
    groups = 0;
    v      = rem;
    do begin
      groups++;
      v = v >> GROUP_BITS;
    end while (v != 0);
    if (pad > groups)
      groups = pad;
    for (int unsigned g = 0; g < groups; g++) begin
      lb = 8'((rem >> (GROUP_BITS * g)) & 32'h7F);
      if (g + 1 < groups)
        lb = lb | CONT_MASK;
      lead.push_back(lb);
    end
    if (with_tlen) begin
      lead.push_back(tlen[15:8]);
      lead.push_back(tlen[7:0]);
    end
    for (int unsigned i = 0; i < lead.size() + body_n && i < cut; i++)
      add_byte((i < lead.size()) ? lead[i] : 8'($urandom), (i == 0) ? st : 1'b0);
  endtask

  // Watchdog: give up once the cycle ceiling is reached.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("mqtt_publish_byte_parser verification failed");
    $finish;
  end

  // Receiver: random stall bursts, one long hold-off, nothing in quiet stretches.
  initial begin
    out_ch.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    out_ch.ready <= 1'b1;
    forever begin
      @(posedge clk);
      if (!hold_done && sent_n >= HOLD_AT) begin
        // Hold off long enough for both parser registers to fill.
        holding   = 1'b1;
        hold_done = 1'b1;
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_ch.ready <= 1'b1;
        holding = 1'b0;
      end else if (!quiet && $urandom_range(0, 11) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk);
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Sender: build the byte plan, reset, then feed it item by item.
  initial begin
    int unsigned pick;
    int unsigned qos;
    int unsigned idb;
    int unsigned tlen;
    int unsigned plen;
    int unsigned pad;
    int unsigned rem;
    int          directed_n;
    logic [7:0]  head;
    logic        st;
    bit          need_start;

    rst             <= 1'b1;
    in_ch.valid      <= 1'b0;
    in_ch.byte_value <= 8'h00;
    in_ch.start_req  <= 1'b0;

    // QoS three from a header with every bit set: the type is not checked,
    // the empty topic goes straight to the identifier, and the zero payload
    // ends the packet on the second identifier byte.
    add_byte(8'hFF, 1'b0);
    add_byte(8'h04, 1'b0);
    add_byte(8'h00, 1'b0);
    add_byte(8'h00, 1'b0);
    add_byte(8'hFF, 1'b0);
    add_byte(8'hFF, 1'b0);
    // Zero remaining length: the length byte carries the error and last.
    add_byte(8'h32, 1'b0);
    add_byte(8'h00, 1'b0);
    // Topic longer than what remains: error, then one discarded byte with last.
    add_byte(8'h30, 1'b0);
    add_byte(8'h03, 1'b0);
    add_byte(8'h00, 1'b0);
    add_byte(8'h05, 1'b0);
    add_byte(8'h00, 1'b0);
    // Overlong length: the fourth length byte still continues; drop what follows.
    add_byte(8'h30, 1'b0);
    add_byte(8'hFF, 1'b0);
    add_byte(8'h80, 1'b0);
    add_byte(8'h80, 1'b0);
    add_byte(8'h80, 1'b0);
    add_byte(8'h55, 1'b0);
    // Largest remaining length, then abort inside the topic with a new header.
    add_byte(8'h34, 1'b1);
    add_byte(8'hFF, 1'b0);
    add_byte(8'hFF, 1'b0);
    add_byte(8'hFF, 1'b0);
    add_byte(8'h7F, 1'b0);
    add_byte(8'h00, 1'b0);
    add_byte(8'h01, 1'b0);
    directed_n = byte_plan.size();
    need_start = 1'b1;

    // Mostly well-formed packets with random content; the rest is aborted,
    // short, overlong and plain noise.
    while (byte_plan.size() < directed_n + RANDOM_ITEMS) begin
      pick = $urandom_range(0, 99);
      qos  = $urandom_range(0, 3);
      head = 8'($urandom);
      head[2:1] = qos[1:0];
      idb  = (qos != 0) ? 2 : 0;
      st   = need_start ? 1'b1 : ($urandom_range(0, 3) == 0);
      tlen = ($urandom_range(0, 15) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 4);
      plen = ($urandom_range(0, 15) == 0) ? $urandom_range(7, 60) : $urandom_range(0, 6);
      pad  = $urandom_range(1, 4);
      if (pick < 65) begin
        add_frame(head, st, 2 + tlen + idb + plen, pad, 1'b1, 16'(tlen),
                  tlen + idb + plen, NO_CUT);
        need_start = 1'b0;
      end else if (pick < 77) begin
        // Cut the packet short; big sizes cost nothing here.
        if ($urandom_range(0, 1) == 1) begin
          tlen = $urandom_range(0, 65535);
          plen = $urandom_range(0, 1 << 27);
        end
        add_frame(head, st, 2 + tlen + idb + plen, pad, 1'b1, 16'(tlen),
                  tlen + idb + plen, $urandom_range(1, 8));
        need_start = 1'b1;
      end else if (pick < 89) begin
        // Remaining length too small for the fields it announces.
        if ($urandom_range(0, 3) == 0) begin
          tlen = $urandom_range(16, 65535);
          rem  = $urandom_range(0, 12);
        end else begin
          rem  = $urandom_range(0, 1 + tlen + idb);
        end
        add_frame(head, st, rem, pad, rem >= 2, 16'(tlen), (rem >= 2) ? rem - 2 : 0, NO_CUT);
        need_start = 1'b0;
      end else if (pick < 95) begin
        add_byte(head, st);
        repeat (LENGTH_BYTES_MAX) add_byte(8'($urandom) | CONT_MASK, 1'b0);
        repeat ($urandom_range(0, 3)) add_byte(8'($urandom), 1'b0);
        need_start = 1'b1;
      end else begin
        repeat ($urandom_range(1, 6)) add_byte(8'($urandom), 1'($urandom));
        need_start = 1'b1;
      end
    end

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    for (int idx = 0; idx < byte_plan.size(); idx++) begin
      // Alternate busy and calm stretches; keep the tail free of gaps.
      quiet = ((idx / 50) % 4 == 2) || (idx + 60 >= byte_plan.size());
      if (!quiet && !holding && $urandom_range(0, 9) == 0) begin
        in_ch.valid <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk);
      end
      in_ch.valid      <= 1'b1;
      in_ch.byte_value <= byte_plan[idx].byte_value;
      in_ch.start_req  <= byte_plan[idx].start_req;
      @(posedge clk);
      while (!in_ch.ready) @(posedge clk);
      sent_n++;
    end
    in_ch.valid <= 1'b0;

    // Drain, then wait for stray results to show up.
    while (pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    if (errors == 0 && pending == 0) begin
      $display("mqtt_publish_byte_parser verification clean");
    end else begin
      $display("mqtt_publish_byte_parser verification failed");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
hdl/mpub_pkg.sv
hdl/mpub_if.sv
hdl/mpub_in_stage.sv
hdl/mpub_decoder.sv
hdl/mpub_out_stage.sv
hdl/mqtt_publish_byte_parser.sv
tb/sv/mqtt_publish_byte_parser_checker.sv
tb/sv/mqtt_publish_byte_parser_test.sv
